>>> hw/rtl/rpm_pkg.sv
// Shared types and constants of the ray parity point-in-mesh block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rpm_pkg;

	localparam int unsigned COORD_W   = 32;
	localparam int unsigned DIFF_W    = COORD_W + 1;   // vertex differences
	localparam int unsigned CNT_W     = 17;
	localparam int unsigned MAX_TRIANGLES = 65536;
	localparam int unsigned COUNT_CAP = (MAX_TRIANGLES < 131071) ? MAX_TRIANGLES : 131071;
	localparam int unsigned IN_W      = 9 * COORD_W;
	localparam int unsigned OUT_W     = 40;            // 1 + 17 + 17 padded to bytes
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_POINT_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_Z = 2'd2;

	typedef logic signed [DIFF_W-1:0] diff_t;

	// u = v1 - v0, v = v2 - v0, w = p - v0
	typedef struct packed {
		diff_t ux, uy, uz;
		diff_t vx, vy, vz;
		diff_t wx, wy, wz;
		logic  last;
	} tri_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} back_state_t;

endpackage

>>> hw/rtl/ray_parity_point_in_mesh.sv
// Top level of the ray parity point-in-mesh block.
// Depends on rpm_pkg, rpm_front, rpm_queue and rpm_back.
`timescale 1ns / 1ps
// Point-in-mesh test: write the query point (point_x/y/z, Q16.16) on the
// cfg port while idle, then stream triangles, one word each; the word with
// tlast set closes the query and yields one result word with the parity
// (inside) flag and the saturating crossing and degenerate counts. The
// front end forms edge vectors on accept and drops them in a two-entry
// queue; the back end runs each triangle through one shared 35x35
// multiplier: a pop, 16 issue steps, a drain step and a decision step.
// Up to two triangles are buffered while the back end works, and the
// output register lets the next query proceed while a result waits.
module ray_parity_point_in_mesh (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write: index 0 point_x, 1 point_y, 2 point_z
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpm_pkg::COORD_W-1:0]    cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// vert0_x, vert0_y, vert0_z, vert1_x, ..., vert2_z (32 bits each)
	input  logic [rpm_pkg::IN_W-1:0]       s_tdata,
	input  logic                           s_tlast,   // last_triangle
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// inside_res[0], crossing_count[17:1], degenerate_count[34:18], zero pad
	output logic [rpm_pkg::OUT_W-1:0]      m_tdata
);
	import rpm_pkg::*;

	tri_t entry, q_data;
	logic q_full, q_nonempty, q_pop, push;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign push      = s_tvalid && s_tready;

	rpm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tri_data  (s_tdata),
		.tri_last  (s_tlast),
		.entry     (entry)
	);

	rpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_data  (q_data)
	);

	rpm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule

>>> hw/rtl/rpm_front.sv
// Front end: query point registers and edge / offset vectors of a triangle.
// Depends on rpm_pkg.
`timescale 1ns / 1ps
module rpm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [rpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpm_pkg::COORD_W-1:0]    cfg_data,
	input  logic [rpm_pkg::IN_W-1:0]       tri_data,
	input  logic                           tri_last,
	output rpm_pkg::tri_t                  entry
);
	import rpm_pkg::*;

	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic signed [COORD_W-1:0] c [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POINT_X: px_q <= cfg_data;
				REG_POINT_Y: py_q <= cfg_data;
				REG_POINT_Z: pz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) c[i] = tri_data[i*COORD_W +: COORD_W];
	end

	always_comb begin
		entry.ux   = DIFF_W'(c[3]) - DIFF_W'(c[0]);
		entry.uy   = DIFF_W'(c[4]) - DIFF_W'(c[1]);
		entry.uz   = DIFF_W'(c[5]) - DIFF_W'(c[2]);
		entry.vx   = DIFF_W'(c[6]) - DIFF_W'(c[0]);
		entry.vy   = DIFF_W'(c[7]) - DIFF_W'(c[1]);
		entry.vz   = DIFF_W'(c[8]) - DIFF_W'(c[2]);
		entry.wx   = DIFF_W'(px_q) - DIFF_W'(c[0]);
		entry.wy   = DIFF_W'(py_q) - DIFF_W'(c[1]);
		entry.wz   = DIFF_W'(pz_q) - DIFF_W'(c[2]);
		entry.last = tri_last;
	end

endmodule

>>> hw/rtl/rpm_queue.sv
// Two-entry queue of prepared triangles between front and back end.
// Depends on rpm_pkg.
`timescale 1ns / 1ps
module rpm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rpm_pkg::tri_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output rpm_pkg::tri_t pop_data
);
	import rpm_pkg::*;

	tri_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/rpm_back.sv
// Back end: shared 35x35 multiplier sequencer, crossing decision, tallies
// and output register. Depends on rpm_pkg.
`timescale 1ns / 1ps
module rpm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_nonempty,
	input  rpm_pkg::tri_t              q_data,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rpm_pkg::OUT_W-1:0]  out_data
);
	import rpm_pkg::*;

	localparam int unsigned OP_W  = 35;
	localparam int unsigned PR_W  = 2 * OP_W;
	localparam int unsigned N_W   = 68;
	localparam int unsigned PL_W  = 104;
	localparam int unsigned HALF  = 34;
	localparam int unsigned CMP_W = N_W + 2;

	typedef enum logic [3:0] {
		MOP_N0A, MOP_N0B, MOP_N1A, MOP_N1B, MOP_N2A, MOP_N2B,
		MOP_SNA, MOP_SNB, MOP_TNA, MOP_TNB,
		MOP_P0L, MOP_P0H, MOP_P1L, MOP_P1H, MOP_P2L, MOP_P2H
	} mop_t;
	localparam logic [4:0] LAST_STEP = 5'd16;

	back_state_t state_q, state_d;
	tri_t        work_q;
	logic [4:0]  step_q;

	logic signed [OP_W-1:0] op_a, op_b;
	logic signed [PR_W-1:0] prod_s1;
	mop_t                   mop_s1;
	logic                   vld_s1;

	logic signed [N_W-1:0]  n0_q, n1_q, n2_q, sn_q, tn_q;
	logic signed [PL_W-1:0] pl_q;

	logic [CNT_W-1:0] hit_q, deg_q;
	logic             par_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic finish, emit_ok;

	function automatic logic signed [OP_W-1:0] ext(input diff_t x);
		return OP_W'(x);
	endfunction

	function automatic logic signed [OP_W-1:0] lo_part(input logic signed [N_W-1:0] x);
		return {1'b0, x[HALF-1:0]};
	endfunction

	function automatic logic signed [OP_W-1:0] hi_part(input logic signed [N_W-1:0] x);
		return OP_W'($signed(x[N_W-1:HALF]));
	endfunction

	// operand selection
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (mop_t'(step_q[3:0]))
			MOP_N0A: begin op_a = ext(work_q.uy); op_b = ext(work_q.vz); end
			MOP_N0B: begin op_a = ext(work_q.uz); op_b = ext(work_q.vy); end
			MOP_N1A: begin op_a = ext(work_q.uz); op_b = ext(work_q.vx); end
			MOP_N1B: begin op_a = ext(work_q.ux); op_b = ext(work_q.vz); end
			MOP_N2A: begin op_a = ext(work_q.ux); op_b = ext(work_q.vy); end
			MOP_N2B: begin op_a = ext(work_q.uy); op_b = ext(work_q.vx); end
			MOP_SNA: begin op_a = ext(work_q.wx); op_b = ext(work_q.vz); end
			MOP_SNB: begin op_a = ext(work_q.wz); op_b = ext(work_q.vx); end
			MOP_TNA: begin op_a = ext(work_q.ux); op_b = ext(work_q.wz); end
			MOP_TNB: begin op_a = ext(work_q.uz); op_b = ext(work_q.wx); end
			MOP_P0L: begin op_a = lo_part(n0_q); op_b = ext(work_q.wx); end
			MOP_P0H: begin op_a = hi_part(n0_q); op_b = ext(work_q.wx); end
			MOP_P1L: begin op_a = lo_part(n1_q); op_b = ext(work_q.wy); end
			MOP_P1H: begin op_a = hi_part(n1_q); op_b = ext(work_q.wy); end
			MOP_P2L: begin op_a = lo_part(n2_q); op_b = ext(work_q.wz); end
			MOP_P2H: begin op_a = hi_part(n2_q); op_b = ext(work_q.wz); end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		mop_s1  <= mop_t'(step_q[3:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= (state_q == ST_RUN) && (step_q != LAST_STEP);
	end

	// accumulation of the registered product
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			case (mop_s1)
				MOP_N0A: n0_q <= N_W'(prod_s1);
				MOP_N0B: n0_q <= n0_q - N_W'(prod_s1);
				MOP_N1A: n1_q <= N_W'(prod_s1);
				MOP_N1B: n1_q <= n1_q - N_W'(prod_s1);
				MOP_N2A: n2_q <= N_W'(prod_s1);
				MOP_N2B: n2_q <= n2_q - N_W'(prod_s1);
				MOP_SNA: sn_q <= N_W'(prod_s1);
				MOP_SNB: sn_q <= sn_q - N_W'(prod_s1);
				MOP_TNA: tn_q <= N_W'(prod_s1);
				MOP_TNB: tn_q <= tn_q - N_W'(prod_s1);
				MOP_P0L: pl_q <= PL_W'(prod_s1);
				MOP_P0H, MOP_P1H, MOP_P2H:
					pl_q <= pl_q + (PL_W'(prod_s1) <<< HALF);
				MOP_P1L, MOP_P2L: pl_q <= pl_q + PL_W'(prod_s1);
				default: ;
			endcase
		end
	end

	// crossing decision; pl_q holds n.w0, the plane distance is its negation
	logic n_zero, pl_zero, pl_pos, dir_neg, dir_zero, behind, in_tri, hit;
	logic signed [CMP_W-1:0] d_c, s_c, t_c, ds_c, dst_c;

	always_comb begin
		n_zero   = (n0_q == '0) && (n1_q == '0) && (n2_q == '0);
		pl_zero  = (pl_q == '0);
		pl_pos   = !pl_q[PL_W-1] && !pl_zero;
		dir_neg  = n1_q[N_W-1];
		dir_zero = (n1_q == '0);
		behind   = !pl_zero && (pl_pos != dir_neg);
		if (!dir_neg) begin
			d_c = CMP_W'(n1_q);
			s_c = -CMP_W'(sn_q);
			t_c = -CMP_W'(tn_q);
		end else begin
			d_c = -CMP_W'(n1_q);
			s_c = CMP_W'(sn_q);
			t_c = CMP_W'(tn_q);
		end
		ds_c   = d_c - s_c;
		dst_c  = ds_c - t_c;
		in_tri = !s_c[CMP_W-1] && !ds_c[CMP_W-1] && !t_c[CMP_W-1] && !dst_c[CMP_W-1];
		if (n_zero)        hit = 1'b0;
		else if (dir_zero) hit = pl_zero;
		else               hit = !behind && in_tri;
	end

	// sequencer
	assign emit_ok = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_nonempty) state_d = ST_RUN;
			ST_RUN:  if (step_q == LAST_STEP) state_d = ST_DONE;
			ST_DONE: if (!work_q.last || emit_ok) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = 1'b0;
		finish = 1'b0;
		case (state_q)
			ST_IDLE: q_pop  = q_nonempty;
			ST_DONE: finish = !work_q.last || emit_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) work_q <= q_data;
	end

	logic [CNT_W-1:0] hit_n, deg_n;
	logic             par_n;

	always_comb begin
		hit_n = hit_q;
		deg_n = deg_q;
		par_n = par_q ^ hit;
		if (hit && (hit_q < CNT_W'(COUNT_CAP)))    hit_n = hit_q + 1'b1;
		if (n_zero && (deg_q < CNT_W'(COUNT_CAP))) deg_n = deg_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			hit_q       <= '0;
			deg_q       <= '0;
			par_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN) step_q <= step_q + 5'd1;
			else                   step_q <= '0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (finish) begin
				if (work_q.last) begin
					hit_q       <= '0;
					deg_q       <= '0;
					par_q       <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					hit_q <= hit_n;
					deg_q <= deg_n;
					par_q <= par_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish && work_q.last)
			out_data_q <= {{(OUT_W - 2*CNT_W - 1){1'b0}}, deg_n, hit_n, par_n};
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> hw/rtl/rpm_checker.sv
// Port-level checks of ray_parity_point_in_mesh, bound to the top level.
// Depends on rpm_pkg.
`timescale 1ns / 1ps
module rpm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [rpm_pkg::OUT_W-1:0] m_tdata
);
	import rpm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word dropped or changed while stalled");

	a_hit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[CNT_W:1] <= CNT_W'(COUNT_CAP))
		else $error("crossing count beyond cap");

	a_deg_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2*CNT_W:CNT_W+1] <= CNT_W'(COUNT_CAP))
		else $error("degenerate count beyond cap");

	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[CNT_W:1] == '0) |-> !m_tdata[0])
		else $error("inside flag set with no crossing");

endmodule

bind ray_parity_point_in_mesh rpm_checker u_rpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/tb_top.sv
// Self-checking testbench of ray_parity_point_in_mesh.
// Needs rpm_pkg and the block's RTL; directed table, extreme points, random meshes.
`timescale 1ns / 1ps
module tb_top;
	import rpm_pkg::*;

	localparam int LAT_CYC    = 60;      // drain wait: back end plus 2 buffered triangles
	localparam int WD_LIMIT   = 20000;   // cycles with no word accepted
	localparam int RAND_ITEMS = 650;

	typedef logic signed [31:0] crd_t;

	// one triangle word: nine coordinates plus the last flag
	typedef struct {
		crd_t c[9];
		logic last;
	} tri_word_t;

	typedef struct packed {
		logic            in_mesh;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] degen;
	} mesh_res_t;

	// directed row: chk says the expected result was typed in
	typedef struct {
		tri_word_t tw;
		logic      chk;
		mesh_res_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	ray_parity_point_in_mesh u_top (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state: query point and running tallies
	crd_t      pt[3];
	logic [CNT_W-1:0] hit_cnt, deg_cnt;
	logic      parity;
	mesh_res_t res_q[$];
	int        n_err = 0;
	int        idle_cyc = 0;
	bit        done = 0;
	bit        hold_off = 0;   // long receiver stall request

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
		return (c < COUNT_CAP) ? c + 1'b1 : c;
	endfunction

	// exact crossing decision for one triangle, all products on 128 bits
	function automatic void judge_tri(tri_word_t tw);
		logic signed [127:0] u[3], v[3], w[3], nrm[3];
		logic signed [127:0] pl, dir, det, sn, tn;
		logic hit;
		for (int i = 0; i < 3; i++) begin
			u[i] = 128'(tw.c[3+i]) - 128'(tw.c[i]);
			v[i] = 128'(tw.c[6+i]) - 128'(tw.c[i]);
			w[i] = 128'(pt[i]) - 128'(tw.c[i]);
		end
		nrm[0] = u[1]*v[2] - u[2]*v[1];
		nrm[1] = u[2]*v[0] - u[0]*v[2];
		nrm[2] = u[0]*v[1] - u[1]*v[0];
		if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0) begin
			deg_cnt = sat_inc(deg_cnt);
			return;
		end
		pl = -(nrm[0]*w[0] + nrm[1]*w[1] + nrm[2]*w[2]);
		dir = nrm[1];
		if (dir == 0)
			hit = (pl == 0);           // ray lies in the plane
		else if (pl != 0 && (pl < 0) != (dir < 0))
			hit = 1'b0;                // plane is below the point
		else begin
			det = -dir;
			sn = w[0]*v[2] - w[2]*v[0];
			tn = u[0]*w[2] - u[2]*w[0];
			if (det < 0) begin
				det = -det; sn = -sn; tn = -tn;
			end
			hit = sn >= 0 && det - sn >= 0 && tn >= 0 && det - (sn + tn) >= 0;
		end
		if (hit) begin
			hit_cnt = sat_inc(hit_cnt);
			parity = ~parity;
		end
	endfunction

	// returns 1 and the result when the triangle closes a query
	function automatic bit mesh_step(tri_word_t tw, output mesh_res_t r);
		judge_tri(tw);
		r = '{parity, hit_cnt, deg_cnt};
		if (!tw.last) return 0;
		hit_cnt = '0; deg_cnt = '0; parity = 1'b0;
		return 1;
	endfunction

	function automatic tri_word_t mk_tri(crd_t a0, crd_t a1, crd_t a2, crd_t b0, crd_t b1,
		crd_t b2, crd_t c0, crd_t c1, crd_t c2, logic lst);
		tri_word_t t;
		t.c = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
		t.last = lst;
		return t;
	endfunction

	// random coordinate: mostly small integers in Q16.16, some full-range values
	function automatic crd_t rnd_crd();
		case ($urandom_range(9))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return crd_t'($signed($urandom_range(8)) - 4) <<< 16;
		endcase
	endfunction

	// random idle gap, never empty
	task automatic rnd_gap();
		int g;
		g = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(2);
		if ($urandom_range(3) == 0) g = 0;
		repeat (g + 1) @(posedge clk);
	endtask

	// valid stays high; set_point drops it after the last register
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, crd_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		pt[idx] = val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_point(crd_t x, crd_t y, crd_t z);
		cfg_write(REG_POINT_X, x);
		cfg_write(REG_POINT_Y, y);
		cfg_write(REG_POINT_Z, z);
		cfg_valid <= 1'b0;
	endtask

	// wait for all results, then let the back end drain before a register write
	task automatic drain();
		while (res_q.size() != 0) @(posedge clk);
		repeat (LAT_CYC) @(posedge clk);
	endtask

	// offer one word; valid stays high when no gap follows
	task automatic send_tri(tri_word_t tw, bit chk, mesh_res_t typed);
		mesh_res_t r;
		logic [IN_W-1:0] d;
		for (int i = 0; i < 9; i++)
			d[32*i +: 32] = tw.c[i];
		s_tdata <= d;
		s_tlast <= tw.last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (mesh_step(tw, r)) begin
			if (chk && r != typed)
				$display("typed result differs from predictor: %h vs %h", typed, r);
			res_q.insert(res_q.size(), chk ? typed : r);
		end
		if ($urandom_range(2) == 0) begin
			s_tvalid <= 1'b0;
			rnd_gap();
		end
	endtask

	// result side: random stalls plus one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end else if ($urandom_range(15) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(3) != 0);
				@(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			mesh_res_t got, want;
			got = '{m_tdata[0], m_tdata[17:1], m_tdata[34:18]};
			if (res_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result word %h", got);
			end else begin
				want = res_q.pop_front();
				if (got != want || m_tdata[39:35] != '0) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: inside %b/%b hits %0d/%0d degen %0d/%0d",
							want.in_mesh, got.in_mesh, want.hits, got.hits,
							want.degen, got.degen);
				end
			end
		end
	end

	// watchdog: cycles with nothing accepted on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cyc <= 0;
		else if (arst_n && !done)
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= WD_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	localparam crd_t ONE = 32'sh0001_0000;
	localparam crd_t MX  = 32'sh7fff_ffff;
	localparam crd_t MN  = 32'sh8000_0000;
	dir_row_t dir_tab[$];
	mesh_res_t nores = '0;

	task automatic add_row(tri_word_t tw, logic chk, mesh_res_t res);
		dir_row_t row;
		row.tw = tw;
		row.chk = chk;
		row.res = res;
		dir_tab.insert(dir_tab.size(), row);
	endtask

	initial begin
		tri_word_t tw;
		int n_q;
		hit_cnt = '0; deg_cnt = '0; parity = 1'b0;
		pt = '{0, 0, 0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; point at origin after reset
		// flat XZ triangle above the point: one crossing
		add_row(mk_tri(-ONE, ONE, -ONE, ONE, ONE, -ONE, 0, ONE, ONE, 1),
			1, '{1'b1, 17'd1, 17'd0});
		// same triangle below the point: behind, no hit
		add_row(mk_tri(-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, -ONE, ONE, 1),
			1, '{1'b0, 17'd0, 17'd0});
		// degenerate: repeated vertex, collinear, all-extreme
		add_row(mk_tri(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, 0), 0, nores);
		add_row(mk_tri(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, 0), 0, nores);
		add_row(mk_tri(MX, MX, MX, MX, MX, MX, MX, MX, MX, 1),
			1, '{1'b0, 17'd0, 17'd3});
		// parallel plane containing the ray (x = 0 plane) and one offset from it
		add_row(mk_tri(0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 0, nores);
		add_row(mk_tri(ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, 1),
			1, '{1'b1, 17'd1, 17'd0});
		// point inside one triangle and on a vertex of another: boundaries count
		add_row(mk_tri(0, ONE, -ONE, ONE, ONE, ONE, -ONE, ONE, ONE, 0), 0, nores);
		add_row(mk_tri(0, ONE, 0, ONE, ONE, 0, 0, ONE, ONE, 0), 0, nores);
		// outside in XZ, point in the plane itself
		add_row(mk_tri(2*ONE, ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 2*ONE, ONE, 3*ONE, 0),
			0, nores);
		add_row(mk_tri(-ONE, 0, -ONE, ONE, 0, -ONE, 0, 0, ONE, 1), 0, nores);
		// extremes of every coordinate
		add_row(mk_tri(MN, MX, MN, MX, MX, MN, 0, MX, MX, 0), 0, nores);
		add_row(mk_tri(MX, MN, MX, MN, MN, MX, MN, MX, 0, 0), 0, nores);
		add_row(mk_tri(MN, MN, MN, MX, MX, MX, -1, 1, -1, 1), 0, nores);
		foreach (dir_tab[i]) send_tri(dir_tab[i].tw, dir_tab[i].chk, dir_tab[i].res);
		s_tvalid <= 1'b0;
		drain();

		// extreme query points
		set_point(MX, MN, MX);
		send_tri(mk_tri(MN, MX, MN, MX, MX, MN, MX, MX, MX, 0), 0, nores);
		send_tri(mk_tri(MX, MN, MX, MX, 0, MN, MN, MX, MX, 1), 0, nores);
		s_tvalid <= 1'b0;
		drain();
		set_point(MN, MX, MN);
		send_tri(mk_tri(MN, MN, MN, MX, MN, MN, MN, MN, MX, 1), 0, nores);
		s_tvalid <= 1'b0;
		drain();

		// random meshes, new point every few queries; long stall once
		n_q = 0;
		for (int k = 0; k < RAND_ITEMS; ) begin
			int len;
			if (n_q % 6 == 0) begin
				s_tvalid <= 1'b0;
				drain();
				if ($urandom_range(3) == 0) set_point($urandom(), $urandom(), $urandom());
				else set_point(rnd_crd(), rnd_crd(), rnd_crd());
			end
			if (n_q == 10) hold_off = 1;
			len = ($urandom_range(4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
			for (int j = 0; j < len; j++) begin
				for (int i = 0; i < 9; i++) tw.c[i] = rnd_crd();
				if ($urandom_range(7) == 0) begin   // force a degenerate one
					tw.c[3] = tw.c[0]; tw.c[4] = tw.c[1]; tw.c[5] = tw.c[2];
				end
				tw.last = (j == len - 1);
				send_tri(tw, 0, nores);
				k++;
			end
			n_q++;
		end
		s_tvalid <= 1'b0;
		while (res_q.size() != 0) @(posedge clk);
		repeat (LAT_CYC) @(posedge clk);
		done = 1;
		if (n_err == 0 && res_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
